/* rtl/core/gss_pkg.sv */
// Shared types and constants of the group sequence stamper.
package gss_pkg;

  // Sizing
  localparam int NUM_GROUPS = 16;
  localparam int MAX_FRAME  = 2048;
  localparam int POS_W      = $clog2(MAX_FRAME + 1);
  localparam int GID_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CNT_W      = 64;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [GID_W-1:0] gid_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Frame layout (byte offsets from the start of the Ethernet header)
  localparam pos_t POS_UDP_SRC   = POS_W'(34);
  localparam pos_t POS_UDP_CSUM  = POS_W'(40);
  localparam pos_t POS_MAGIC     = POS_W'(42);
  localparam pos_t POS_PORT_COPY = POS_W'(50);
  localparam pos_t POS_SESSION   = POS_W'(52);
  localparam pos_t POS_COUNT     = POS_W'(60);
  localparam pos_t POS_GROUPS    = POS_W'(64);
  localparam pos_t POS_FRAME_END = POS_W'(MAX_FRAME);

  // Group entry: 4 ID bytes then 8 sequence bytes
  localparam logic [3:0] ENTRY_LAST = 4'd11;
  localparam logic [3:0] ID_LAST    = 4'd3;
  localparam logic [3:0] SEQ_FIRST  = 4'd4;

  // Configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_SESSION_ID = 1'd0;
  localparam cfg_idx_t REG_MAGIC      = 1'd1;

  // Counter bank request
  typedef struct packed {
    logic inc;
    gid_t grp;
  } cnt_req_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fwd;
  } result_t;

endpackage

/* rtl/core/gss_counters.sv */
// Per-group 64-bit sequence counters with read-increment-write.
module gss_counters (
  input  logic              clk,
  input  logic              rst_n,
  input  gss_pkg::cnt_req_t req,
  output gss_pkg::cnt_t     next_val
);

  gss_pkg::cnt_t cnt_r [gss_pkg::NUM_GROUPS];

  assign next_val = cnt_r[req.grp] + gss_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gss_pkg::NUM_GROUPS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (req.inc) begin
      cnt_r[req.grp] <= next_val;
    end
  end

endmodule

/* rtl/core/gss_parse.sv */
// Frame position tracking, field capture and byte rewrite.
module gss_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic [63:0]       session_id,
  input  logic [31:0]       magic,
  input  gss_pkg::cnt_t     cnt_next,
  output gss_pkg::cnt_req_t cnt_req,
  output gss_pkg::result_t  res
);

  gss_pkg::pos_t pos_r, pos_nxt;
  logic [15:0]   port_r, port_nxt;
  logic [31:0]   magic_r, magic_nxt;
  logic          ok_r, ok_nxt;
  logic [7:0]    left_r, left_nxt;
  logic [31:0]   gid_r, gid_nxt;
  gss_pkg::cnt_t stamp_r, stamp_nxt;
  logic [3:0]    k_r, k_nxt;
  logic [2:0]    sess_sel, seq_sel;

  assign sess_sel = 3'(pos_r - gss_pkg::POS_SESSION);
  assign seq_sel  = 3'(k_r - gss_pkg::SEQ_FIRST);

  always_comb begin
    pos_nxt   = pos_r;
    port_nxt  = port_r;
    magic_nxt = magic_r;
    ok_nxt    = ok_r;
    left_nxt  = left_r;
    gid_nxt   = gid_r;
    stamp_nxt = stamp_r;
    k_nxt     = k_r;
    cnt_req   = '0;
    res.data  = in_byte;
    res.last  = in_last;
    res.fwd   = 1'b0;

    if (acc) begin
      if (pos_r < gss_pkg::POS_FRAME_END) begin
        pos_nxt = pos_r + gss_pkg::POS_W'(1);
        if (pos_r == gss_pkg::POS_UDP_SRC) begin
          port_nxt = {in_byte, port_r[7:0]};
        end else if (pos_r == gss_pkg::POS_UDP_SRC + gss_pkg::POS_W'(1)) begin
          port_nxt = {port_r[15:8], in_byte};
        end else if (pos_r == gss_pkg::POS_UDP_CSUM ||
                     pos_r == gss_pkg::POS_UDP_CSUM + gss_pkg::POS_W'(1)) begin
          res.data = 8'h00;
        end else if (pos_r >= gss_pkg::POS_MAGIC &&
                     pos_r < gss_pkg::POS_MAGIC + gss_pkg::POS_W'(4)) begin
          magic_nxt = {in_byte, magic_r[31:8]};
          if (pos_r == gss_pkg::POS_MAGIC + gss_pkg::POS_W'(3)) begin
            ok_nxt = (magic_nxt == magic);
          end
        end else if (ok_r && pos_r == gss_pkg::POS_PORT_COPY) begin
          res.data = port_r[15:8];
        end else if (ok_r && pos_r == gss_pkg::POS_PORT_COPY + gss_pkg::POS_W'(1)) begin
          res.data = port_r[7:0];
        end else if (ok_r && pos_r >= gss_pkg::POS_SESSION &&
                     pos_r < gss_pkg::POS_SESSION + gss_pkg::POS_W'(8)) begin
          res.data = session_id[{sess_sel, 3'b000} +: 8];
        end else if (ok_r && pos_r == gss_pkg::POS_COUNT) begin
          left_nxt = in_byte;
        end else if (ok_r && pos_r >= gss_pkg::POS_GROUPS && left_r != 8'd0) begin
          // entry byte index runs continuously from the first entry
          k_nxt = (k_r == gss_pkg::ENTRY_LAST) ? 4'd0 : k_r + 4'd1;
          if (k_r < gss_pkg::SEQ_FIRST) begin
            gid_nxt = {in_byte, gid_r[31:8]};
            if (k_r == gss_pkg::ID_LAST) begin
              if (gid_nxt >= 32'(gss_pkg::NUM_GROUPS)) begin
                ok_nxt = 1'b0;
              end else begin
                cnt_req.inc = 1'b1;
                cnt_req.grp = gid_nxt[gss_pkg::GID_W-1:0];
                stamp_nxt   = cnt_next;
              end
            end
          end else begin
            res.data = stamp_r[{seq_sel, 3'b000} +: 8];
            if (k_r == gss_pkg::ENTRY_LAST) begin
              left_nxt = left_r - 8'd1;
            end
          end
        end
      end

      if (in_last) begin
        res.fwd   = ok_nxt && (pos_r >= gss_pkg::POS_GROUPS - gss_pkg::POS_W'(1));
        pos_nxt   = '0;
        port_nxt  = '0;
        magic_nxt = '0;
        ok_nxt    = 1'b0;
        left_nxt  = '0;
        gid_nxt   = '0;
        stamp_nxt = '0;
        k_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      port_r  <= '0;
      magic_r <= '0;
      ok_r    <= 1'b0;
      left_r  <= '0;
      gid_r   <= '0;
      stamp_r <= '0;
      k_r     <= '0;
    end else begin
      pos_r   <= pos_nxt;
      port_r  <= port_nxt;
      magic_r <= magic_nxt;
      ok_r    <= ok_nxt;
      left_r  <= left_nxt;
      gid_r   <= gid_nxt;
      stamp_r <= stamp_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

/* rtl/core/gss_out_buf.sv */
// Result register with a one-item skid stage.
module gss_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gss_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output gss_pkg::result_t out_data
);

  logic             out_valid_r;
  gss_pkg::result_t out_data_r;
  logic             skid_valid_r;
  gss_pkg::result_t skid_data_r;

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
        out_data_r  <= push_data;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= push_data;
    end
  end

endmodule

/* rtl/core/group_sequence_stamper_core.sv */
// Top level of the group sequence stamper.
// Byte-serial rewriter for Ethernet/IPv4/UDP frames (IPv4 header fixed at 20 bytes).
// One byte item per clock while out_stall does not hold the results: each
// byte is rewritten combinationally and its result is registered; the
// longest path is the group counter read, 64-bit increment and write-back on
// the last group ID byte. A one-item skid stage behind the result register
// lets in_stall come from a register, so a byte can be taken while a result
// still waits. Sequenced frames get the UDP source port copied to frame
// bytes 50..51, the session ID at 52..59 and, per listed group, that group's
// incremented counter after the group ID; UDP checksum bytes are zeroed.
// out_forward on the last byte says whether the frame was sequenced.
// Write configuration through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module group_sequence_stamper_core (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic                  out_forward,
  // configuration
  input  logic                  cfg_we,
  input  gss_pkg::cfg_idx_t     cfg_index,
  input  logic [63:0]           cfg_data
);

  logic              acc;
  logic [63:0]       session_id_r;
  logic [31:0]       magic_r;
  gss_pkg::cnt_req_t cnt_req;
  gss_pkg::cnt_t     cnt_next;
  gss_pkg::result_t  res;
  gss_pkg::result_t  out_res;

  assign acc = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_id_r <= '0;
      magic_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gss_pkg::REG_SESSION_ID: session_id_r <= cfg_data;
        gss_pkg::REG_MAGIC:      magic_r      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Frame parser and rewrite
  gss_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .session_id (session_id_r),
    .magic      (magic_r),
    .cnt_next   (cnt_next),
    .cnt_req    (cnt_req),
    .res        (res)
  );

  // Group counters
  gss_counters u_counters (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (cnt_req),
    .next_val (cnt_next)
  );

  // Result register and skid
  gss_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_byte    = out_res.data;
  assign out_last    = out_res.last;
  assign out_forward = out_res.fwd;

  // Skid holds an item only behind a full result register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid occupied with result register empty");

  // Forward decision only rides on the last byte
  a_fwd_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_forward) |-> out_last)
    else $error("forward set on a byte that is not last");

  // Counters move only for a taken item
  a_inc_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_req.inc |-> acc)
    else $error("counter increment without an accepted item");

endmodule

/* tb/gss_stamp_checker.sv */
// Checker for the group sequence stamper: predicts every result item and compares it.
`timescale 1ns / 1ps

module gss_stamp_checker
  import gss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        out_forward,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [63:0] cfg_data,
  output int          fault_count,
  output int          bytes_in_flight
);

  localparam int ENTRY_BYTES = int'(ENTRY_LAST) + 1;
  localparam int MAX_REPORTS = 40;

  // registers as last written
  logic [63:0] session_val;
  logic [31:0] magic_val;

  // per-frame state
  int unsigned frame_pos;
  logic [15:0] src_port;
  logic [31:0] magic_acc;
  logic        seq_ok;
  logic [7:0]  groups_to_stamp;
  logic [31:0] gid_acc;
  logic [63:0] stamp_val;
  logic [63:0] group_count [NUM_GROUPS];

  result_t     expected_bytes [$];
  int          results_seen;

  task automatic report_mismatch(input string what);
    if (fault_count < MAX_REPORTS)
      $display("%0t ns: result %0d: %s", $time, results_seen, what);
    fault_count++;
  endtask

  task automatic clear_frame();
    frame_pos       = 0;
    src_port        = '0;
    magic_acc       = '0;
    seq_ok          = 1'b0;
    groups_to_stamp = '0;
    gid_acc         = '0;
    stamp_val       = '0;
  endtask

  // Expected rewrite of one byte; advances the frame state.
  task automatic stamp_byte(input logic [7:0] b, input logic l, output result_t r);
    int unsigned pos;
    int unsigned k;
    logic [7:0]  ob;
    pos = frame_pos;
    ob  = b;
    if (pos < MAX_FRAME) begin
      if (pos == POS_UDP_SRC) begin
        src_port[15:8] = b;
      end else if (pos == POS_UDP_SRC + 1) begin
        src_port[7:0] = b;
      end else if (pos == POS_UDP_CSUM || pos == POS_UDP_CSUM + 1) begin
        ob = 8'h00;
      end else if (pos >= POS_MAGIC && pos < POS_MAGIC + 4) begin
        magic_acc = {b, magic_acc[31:8]};
        if (pos == POS_MAGIC + 3) seq_ok = (magic_acc == magic_val);
      end else if (seq_ok && pos == POS_PORT_COPY) begin
        ob = src_port[15:8];
      end else if (seq_ok && pos == POS_PORT_COPY + 1) begin
        ob = src_port[7:0];
      end else if (seq_ok && pos >= POS_SESSION && pos < POS_SESSION + 8) begin
        ob = session_val[8 * (pos - POS_SESSION) +: 8];
      end else if (seq_ok && pos == POS_COUNT) begin
        groups_to_stamp = b;
      end else if (seq_ok && pos >= POS_GROUPS && groups_to_stamp != 0) begin
        k = (pos - POS_GROUPS) % ENTRY_BYTES;
        if (k <= ID_LAST) begin
          gid_acc = {b, gid_acc[31:8]};
          if (k == ID_LAST) begin
            if (gid_acc >= NUM_GROUPS) begin
              seq_ok = 1'b0;
            end else begin
              group_count[gid_acc] = group_count[gid_acc] + 64'd1;
              stamp_val = group_count[gid_acc];
            end
          end
        end else begin
          ob = stamp_val[8 * (k - SEQ_FIRST) +: 8];
          if (k == ENTRY_LAST) groups_to_stamp = groups_to_stamp - 8'd1;
        end
      end
      frame_pos = pos + 1;
    end
    r.data = ob;
    r.last = l;
    r.fwd  = l && seq_ok && (pos >= POS_GROUPS - 1);
    if (l) clear_frame();
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t pred;
    if (!rst_n) begin
      session_val = '0;
      magic_val   = '0;
      for (int g = 0; g < NUM_GROUPS; g++) group_count[g] = '0;
      clear_frame();
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected result, byte %h", out_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("byte %h, want %h", out_byte, want.data));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_last, want.last));
          if (out_forward !== want.fwd)
            report_mismatch($sformatf("forward %b, want %b", out_forward, want.fwd));
        end
        results_seen++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SESSION_ID: session_val = cfg_data;
          REG_MAGIC:      magic_val   = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        stamp_byte(in_byte, in_last, pred);
        expected_bytes.push_back(pred);
      end
    end
    bytes_in_flight <= expected_bytes.size();
  end

endmodule

/* tb/tb_group_sequence_stamper_core.sv */
// Testbench top for the group sequence stamper: frame stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module tb_group_sequence_stamper_core;
  import gss_pkg::*;

  // Generous: the slowest phases idle or stall at 77 percent, and the
  // whole run sends under three thousand bytes.
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 4;
  localparam int PHASE_BYTES = 100;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte     = 8'h00;
  logic        in_last     = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_forward;
  logic        cfg_we      = 1'b0;
  cfg_idx_t    cfg_index   = REG_SESSION_ID;
  logic [63:0] cfg_data    = '0;

  int          fault_count;
  int          bytes_in_flight;

  // idling odds, in percent, set per phase
  int          idle_pct    = 0;
  int          stall_pct   = 0;

  int          cycle_count = 0;
  int          bytes_sent  = 0;
  int          hold_at     = -1;   // byte count at which the sender waits for a full drain
  logic [31:0] cur_magic   = '0;   // magic the DUT currently holds
  logic [7:0]  frame_buf [$];

  always #6 clk = ~clk;

  group_sequence_stamper_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_forward (out_forward),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  gss_stamp_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_forward     (out_forward),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fault_count     (fault_count),
    .bytes_in_flight (bytes_in_flight)
  );

  // Receiver: stalls at random with the phase's odds, redrawn each cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // One byte item: optional idle gap, then hold it until taken.
  // in_valid stays high across back-to-back items so it is never
  // dropped and raised again within one step.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Sender goes quiet until every predicted result has been checked. The first
  // edge lets the checker count the item taken on the step we were called in.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Only called with the DUT drained; it waits idle before the writes.
  task automatic set_config(input logic [63:0] session, input logic [63:0] magic);
    repeat (3) @(posedge clk);
    write_reg(REG_SESSION_ID, session);
    write_reg(REG_MAGIC, magic);
    cur_magic = magic[31:0];
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 77; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 77; end
      default: begin idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  // Random bytes, then the payload header laid over them: magic word, group
  // count word and one little-endian group ID per 12-byte entry, as far as
  // the frame reaches. Entry bad_entry (if any) gets bad_gid instead.
  task automatic build_frame(input int len, input logic [31:0] magic_word,
                             input logic [31:0] count_word, input int bad_entry,
                             input logic [31:0] bad_gid);
    int          n;
    int          e;
    int          base;
    logic [31:0] gid;
    frame_buf.delete();
    for (n = 0; n < len; n++) frame_buf.push_back(8'($urandom));
    for (n = 0; n < 4; n++) begin
      if (POS_MAGIC + n < len) frame_buf[POS_MAGIC + n] = magic_word[8*n +: 8];
      if (POS_COUNT + n < len) frame_buf[POS_COUNT + n] = count_word[8*n +: 8];
    end
    for (e = 0; POS_GROUPS + 12 * e < len; e++) begin
      base = POS_GROUPS + 12 * e;
      gid  = (e == bad_entry) ? bad_gid : 32'($urandom_range(NUM_GROUPS - 1, 0));
      for (n = 0; n < 4; n++)
        if (base + n < len) frame_buf[base + n] = gid[8*n +: 8];
    end
  endtask

  task automatic send_frame();
    for (int n = 0; n < frame_buf.size(); n++) begin
      send_byte(frame_buf[n], n == frame_buf.size() - 1);
      if (bytes_sent == hold_at) wait_for_results();
    end
  endtask

  task automatic play_frame(input int len, input logic [31:0] magic_word,
                            input logic [31:0] count_word, input int bad_entry,
                            input logic [31:0] bad_gid);
    build_frame(len, magic_word, count_word, bad_entry, bad_gid);
    send_frame();
  endtask

  task automatic play_noise(input int len);
    frame_buf.delete();
    for (int n = 0; n < len; n++) frame_buf.push_back(8'($urandom));
    send_frame();
  endtask

  // Mostly well-formed frames with random content; the rest wrong magic,
  // odd lengths, mismatched counts, bad group IDs or plain noise.
  task automatic random_frame();
    int          sel;
    int          ng;
    int          len;
    int          bad;
    logic [31:0] cnt;
    logic [31:0] bad_gid;
    sel = $urandom_range(99);
    ng  = $urandom_range(4);
    if ($urandom_range(19) == 0) ng = $urandom_range(20);
    len = POS_GROUPS + 12 * ng;
    if ($urandom_range(3) == 0) len = len + $urandom_range(24) - 12;
    if (len < 1) len = 1;
    cnt = $urandom;
    cnt[7:0] = 8'(ng);
    if ($urandom_range(7) == 0) cnt[7:0] = 8'($urandom_range(255));
    bad = ($urandom_range(9) == 0) ? $urandom_range(ng) : -1;
    bad_gid = $urandom_range(1) ? 32'($urandom_range(NUM_GROUPS + 3, NUM_GROUPS))
                                : ($urandom | 32'h0100_0000);
    if (sel < 12) begin
      // magic almost surely wrong
      play_frame(len, $urandom, cnt, bad, bad_gid);
    end else if (sel < 24) begin
      play_noise($urandom_range(80, 1));
    end else begin
      play_frame(len, cur_magic, cnt, bad, bad_gid);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still at reset: magic zero, session zero.
    set_idling(3);
    play_frame(80, 32'h0, 32'd1, -1, '0);
    wait_for_results();
    set_config('1, '1);

    // Directed frames
    play_noise(1);                                            // one-byte frame
    play_frame(64, cur_magic, 32'd0, -1, '0);                 // shortest frame forwarded
    play_frame(63, cur_magic, 32'd3, -1, '0);                 // one byte short of the count
    play_frame(100, ~cur_magic, 32'd2, -1, '0);               // magic mismatch
    play_frame(76, cur_magic, 32'd1, -1, '0);                 // one full entry, ends on it
    play_frame(100, cur_magic, 32'hFFFF_FF02, -1, '0);        // only byte 60 counts
    play_frame(112, cur_magic, 32'd3, 0, NUM_GROUPS);         // first ID just out of range
    play_frame(112, cur_magic, 32'd4, 1, 32'hFFFF_FFFF);      // bad ID after a good one
    play_frame(66, cur_magic, 32'd1, -1, '0);                 // ID cut by frame end
    play_frame(71, cur_magic, 32'd2, -1, '0);                 // sequence bytes cut short
    play_frame(88, cur_magic, 32'd255, -1, '0);               // count runs past the end
    play_frame(41, cur_magic, 32'd1, -1, '0);                 // ends on a checksum byte
    play_frame(45, cur_magic, 32'd1, -1, '0);                 // ends on the magic
    wait_for_results();

    // Random phases, each with its own register setting and idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      int phase_end;
      wait_for_results();
      case (ph % 4)
        0: set_config({$urandom, $urandom}, {$urandom, $urandom});
        1: set_config('0, '0);
        2: set_config('1, {$urandom, $urandom});
        default: set_config({$urandom, $urandom}, 64'h0000_0000_FFFF_FFFF);
      endcase
      set_idling(ph + 1);
      hold_at   = bytes_sent + $urandom_range(PHASE_BYTES - 1, 1);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) random_frame();
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
